FILE: sv/vertex_normal_accumulator_assert.svh
// Assertion macros for the vertex normal accumulator.
`ifndef VERTEX_NORMAL_ACCUMULATOR_ASSERT_SVH
`define VERTEX_NORMAL_ACCUMULATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define VNA_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: label");
`define VNA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");
`else
`define VNA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define VNA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: sv/vna_pkg.sv
package vna_pkg;

  localparam int unsigned OpcodeWidth = 2;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned CountWidth  = 11;
  localparam int unsigned SqWidth     = 64;
  localparam int unsigned MagWidth    = 31;
  localparam int unsigned QuotWidth   = 16;

  typedef enum logic [OpcodeWidth-1:0] {
    OP_LOAD = 2'd0,
    OP_FACE = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_ZERO  = 2'd2,
    ST_SPARE = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [15:0]        vertex_index;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [15:0]        face_a;
    logic [15:0]        face_b;
    logic [15:0]        face_c;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
  } out_item_t;

  // Request and answer between the controller and the normalizer.
  typedef struct packed {
    logic            start;
    logic [MagWidth-1:0] mx;
    logic [MagWidth-1:0] my;
    logic [MagWidth-1:0] mz;
  } norm_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] qx;
    logic [15:0] qy;
    logic [15:0] qz;
  } norm_rsp_t;

endpackage

FILE: sv/vna_norm.sv
// Iterative normalizer: squares, integer square root one bit a step, then
// three restoring divisions one quotient bit a step.
module vna_norm
  import vna_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  norm_req_t req,
  output norm_rsp_t rsp
);

  typedef enum logic [2:0] {
    S_IDLE, S_SQ, S_SUM, S_ROOT, S_DIV, S_DONE
  } nstate_t;

  nstate_t state;
  logic [MagWidth-1:0] m [3];
  logic [SqWidth-1:0] sq;
  logic [SqWidth-1:0] rem_root;
  logic [SqWidth-1:0] root;
  logic [SqWidth-1:0] bitv;
  logic [1:0] sq_idx;
  logic [1:0] div_idx;
  logic [5:0] div_cnt;
  logic [MagWidth+14:0] num;
  logic [MagWidth+15:0] drem;
  logic [31:0] len;
  logic [16:0] quo;
  logic [15:0] q [3];
  logic done;

  logic [SqWidth-1:0] root_trial;
  logic [MagWidth+15:0] drem_shift;
  logic [2*MagWidth-1:0] sq_term;

  always_comb begin
    root_trial = root + bitv;
    drem_shift = {drem[MagWidth+14:0], num[MagWidth+14]};
    sq_term = m[sq_idx] * m[sq_idx];
  end

  // Square, root and division sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.start) begin
            m[0] <= req.mx;
            m[1] <= req.my;
            m[2] <= req.mz;
            sq <= '0;
            sq_idx <= 2'd0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          sq <= sq + SqWidth'(sq_term);
          if (sq_idx == 2'd2) begin
            state <= S_SUM;
          end
          sq_idx <= sq_idx + 2'd1;
        end
        S_SUM: begin
          rem_root <= sq;
          root <= '0;
          bitv <= SqWidth'(1) << 62;
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (bitv != '0) begin
            if (rem_root >= root_trial) begin
              rem_root <= rem_root - root_trial;
              root <= (root >> 1) + bitv;
            end else begin
              root <= root >> 1;
            end
            bitv <= bitv >> 2;
          end else begin
            len <= root[31:0];
            div_idx <= 2'd0;
            num <= {m[0], 14'd0} + (MagWidth+15)'(root[31:1]);
            drem <= '0;
            quo <= '0;
            div_cnt <= 6'd0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_cnt == 6'(MagWidth + 15)) begin
            q[div_idx] <= quo[15:0];
            if (div_idx == 2'd2) begin
              state <= S_DONE;
            end else begin
              num <= {m[div_idx + 2'd1], 14'd0} + (MagWidth+15)'(len[31:1]);
              drem <= '0;
              quo <= '0;
              div_cnt <= 6'd0;
            end
            div_idx <= div_idx + 2'd1;
          end else begin
            num <= num << 1;
            if (drem_shift >= (MagWidth+16)'(len)) begin
              drem <= drem_shift - (MagWidth+16)'(len);
              quo <= {quo[15:0], 1'b1};
            end else begin
              drem <= drem_shift;
              quo <= {quo[15:0], 1'b0};
            end
            div_cnt <= div_cnt + 6'd1;
          end
        end
        S_DONE: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.qx = q[0];
  assign rsp.qy = q[1];
  assign rsp.qz = q[2];

endmodule

FILE: sv/vna_store.sv
// Vertex memories: positions and accumulated sums, one read port with
// registered data and one write port each.
module vna_store
  import vna_pkg::*;
#(
  parameter int unsigned Depth    = 1024,
  parameter int unsigned AccWidth = 48,
  parameter int unsigned AddrW    = 10
) (
  input  logic                clk,
  input  logic [AddrW-1:0]    raddr,
  output logic [47:0]         pos_rd,
  output logic [3*AccWidth-1:0] sum_rd,
  input  logic                pos_we,
  input  logic [AddrW-1:0]    pos_waddr,
  input  logic [47:0]         pos_wd,
  input  logic                sum_we,
  input  logic [AddrW-1:0]    sum_waddr,
  input  logic [3*AccWidth-1:0] sum_wd
);

  logic [47:0]           pos_mem [Depth];
  logic [3*AccWidth-1:0] sum_mem [Depth];

  // Position memory.
  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wd;
    end
    pos_rd <= pos_mem[raddr];
  end

  // Sum memory.
  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_waddr] <= sum_wd;
    end
    sum_rd <= sum_mem[raddr];
  end

endmodule

FILE: sv/vertex_normal_accumulator.sv
// Channel  | Direction | Handshake     | Payload
// in       | input     | valid / stall | in_item_t
// out      | output    | valid / stall | out_item_t
// cfg      | input     | valid / ready | vertex_count, 11 bits
//
// One item at a time. From acceptance to a valid result, a face runs three
// position reads, the cross product and three read-modify-writes of the sum
// memory; a read runs squares, a 32-step square root and three divisions in
// the shared normalizer. A zero-sum read skips the normalizer. The next item
// is accepted only once the result has been taken.
// Reset clears control state only; memories are undefined until loaded.
// A finished item waits in the output register while out_stall is high, and
// the input stalls while a configuration write is offered.
module vertex_normal_accumulator
  import vna_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned ACC_WIDTH    = 48
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [10:0] cfg_data
);

  `include "vertex_normal_accumulator_assert.svh"

  localparam int unsigned AddrW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam logic signed [ACC_WIDTH-1:0] AccMax = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] AccMin = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  typedef enum logic [3:0] {
    C_IDLE, C_CHECK, C_RDA, C_RDB, C_RDC, C_CR1, C_CR2,
    C_RMW_RD, C_RMW_WAIT, C_RMW_WR, C_LOAD, C_READ_WAIT, C_READ_NORM,
    C_NORM_WAIT, C_OUT
  } cstate_t;

  cstate_t state;
  logic [10:0] vertex_count;
  in_item_t item;
  out_item_t res;
  logic [AddrW-1:0] raddr;
  logic [47:0] pos_rd;
  logic [3*ACC_WIDTH-1:0] sum_rd;
  logic pos_we, sum_we;
  logic [AddrW-1:0] sum_waddr;
  logic [3*ACC_WIDTH-1:0] sum_wd;
  logic signed [15:0] pa [3];
  logic signed [15:0] pb [3];
  logic signed [16:0] e1 [3];
  logic signed [16:0] e2 [3];
  logic signed [33:0] pr [6];
  logic signed [34:0] cr [3];
  logic [1:0] rmw_idx;
  logic [AddrW-1:0] rmw_addr;
  logic [2:0] neg;
  norm_req_t nreq;
  norm_rsp_t nrsp;
  logic [16:0] lim;
  logic range_err;
  logic [63:0] mg [3];
  logic [63:0] mmax;
  logic [5:0] lz;
  logic [MagWidth-1:0] sm [3];

  vna_store #(.Depth(MAX_VERTICES), .AccWidth(ACC_WIDTH), .AddrW(AddrW)) u_store (
    .clk, .raddr, .pos_rd, .sum_rd,
    .pos_we, .pos_waddr(item.vertex_index[AddrW-1:0]),
    .pos_wd({item.pos_x, item.pos_y, item.pos_z}),
    .sum_we, .sum_waddr, .sum_wd
  );

  vna_norm u_norm (.clk, .rst, .req(nreq), .rsp(nrsp));

  assign cfg_ready = (state == C_IDLE) && !out_valid;
  assign in_stall  = (state != C_IDLE) || out_valid || cfg_valid;

  // Usable index limit.
  always_comb begin
    lim = (17'(vertex_count) < 17'(MAX_VERTICES)) ? 17'(vertex_count) : 17'(MAX_VERTICES);
    case (item.opcode)
      OP_FACE: range_err = (17'(item.face_a) >= lim) || (17'(item.face_b) >= lim) ||
                           (17'(item.face_c) >= lim);
      OP_LOAD, OP_READ: range_err = 17'(item.vertex_index) >= lim;
      default: range_err = 1'b0;
    endcase
  end

  // Vertex addressed by the current read-modify-write pass.
  always_comb begin
    case (rmw_idx)
      2'd0: rmw_addr = item.face_a[AddrW-1:0];
      2'd1: rmw_addr = item.face_b[AddrW-1:0];
      default: rmw_addr = item.face_c[AddrW-1:0];
    endcase
  end

  // Saturating add of one cross component to one stored sum.
  function automatic logic [ACC_WIDTH-1:0] sat_add(input logic [ACC_WIDTH-1:0] s,
                                                   input logic signed [34:0] d);
    logic signed [ACC_WIDTH:0] t;
    t = $signed({s[ACC_WIDTH-1], s}) + (ACC_WIDTH+1)'(d);
    if (t > $signed({AccMax[ACC_WIDTH-1], AccMax})) return AccMax;
    if (t < $signed({AccMin[ACC_WIDTH-1], AccMin})) return AccMin;
    return t[ACC_WIDTH-1:0];
  endfunction

  // Magnitudes and common scaling for the normalizer.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [ACC_WIDTH-1:0] s;
      s = sum_rd[(2-i)*ACC_WIDTH +: ACC_WIDTH];
      mg[i] = s[ACC_WIDTH-1] ? (64'(~s) + 64'd1) & ((64'd1 << ACC_WIDTH) - 64'd1) : 64'(s);
    end
    mmax = (mg[0] > mg[1]) ? mg[0] : mg[1];
    mmax = (mg[2] > mmax) ? mg[2] : mmax;
    lz = '0;
    for (int k = 63; k >= 0; k--) begin
      if (mmax[k] && lz == 6'd0) lz = 6'(k);
    end
    for (int i = 0; i < 3; i++) begin
      if (lz >= 6'd30) sm[i] = MagWidth'(mg[i] >> (lz - 6'd29));
      else sm[i] = MagWidth'(mg[i] << (6'd29 - lz));
    end
  end

  // Controller: one item at a time through the memories.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      out_valid <= 1'b0;
      vertex_count <= '0;
      pos_we <= 1'b0;
      sum_we <= 1'b0;
      nreq.start <= 1'b0;
    end else begin
      pos_we <= 1'b0;
      sum_we <= 1'b0;
      nreq.start <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        vertex_count <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        C_IDLE: begin
          if (in_valid && !in_stall) begin
            item <= in_item;
            state <= C_CHECK;
          end
        end
        C_CHECK: begin
          res.status <= range_err ? ST_RANGE : ST_OK;
          res.normal_x <= '0;
          res.normal_y <= '0;
          res.normal_z <= '0;
          if (range_err) begin
            state <= C_OUT;
          end else begin
            case (item.opcode)
              OP_LOAD: begin
                pos_we <= 1'b1;
                sum_we <= 1'b1;
                sum_waddr <= item.vertex_index[AddrW-1:0];
                sum_wd <= '0;
                state <= C_LOAD;
              end
              OP_FACE: begin
                raddr <= item.face_a[AddrW-1:0];
                state <= C_RDA;
              end
              OP_READ: begin
                raddr <= item.vertex_index[AddrW-1:0];
                state <= C_READ_WAIT;
              end
              default: state <= C_OUT;
            endcase
          end
        end
        C_LOAD: state <= C_OUT;
        C_RDA: begin
          raddr <= item.face_b[AddrW-1:0];
          state <= C_RDB;
        end
        C_RDB: begin
          pa[0] <= pos_rd[47:32]; pa[1] <= pos_rd[31:16]; pa[2] <= pos_rd[15:0];
          raddr <= item.face_c[AddrW-1:0];
          state <= C_RDC;
        end
        C_RDC: begin
          pb[0] <= pos_rd[47:32]; pb[1] <= pos_rd[31:16]; pb[2] <= pos_rd[15:0];
          for (int i = 0; i < 3; i++) begin
            e1[i] <= 17'(pa[i]) - 17'(signed'(pos_rd[(2-i)*16 +: 16]));
          end
          state <= C_CR1;
        end
        C_CR1: begin
          for (int i = 0; i < 3; i++) begin
            e2[i] <= 17'(signed'(pos_rd[(2-i)*16 +: 16])) - 17'(pb[i]);
          end
          state <= C_CR2;
        end
        C_CR2: begin
          pr[0] <= e1[1] * e2[2]; pr[1] <= e1[2] * e2[1];
          pr[2] <= e1[2] * e2[0]; pr[3] <= e1[0] * e2[2];
          pr[4] <= e1[0] * e2[1]; pr[5] <= e1[1] * e2[0];
          rmw_idx <= 2'd0;
          state <= C_RMW_RD;
        end
        C_RMW_RD: begin
          if (rmw_idx == 2'd0) begin
            cr[0] <= 35'(pr[0]) - 35'(pr[1]);
            cr[1] <= 35'(pr[2]) - 35'(pr[3]);
            cr[2] <= 35'(pr[4]) - 35'(pr[5]);
          end
          raddr <= rmw_addr;
          sum_waddr <= rmw_addr;
          state <= C_RMW_WAIT;
        end
        C_RMW_WAIT: state <= C_RMW_WR;
        C_RMW_WR: begin
          sum_we <= 1'b1;
          for (int i = 0; i < 3; i++) begin
            sum_wd[(2-i)*ACC_WIDTH +: ACC_WIDTH] <=
              sat_add(sum_rd[(2-i)*ACC_WIDTH +: ACC_WIDTH], cr[i]);
          end
          if (rmw_idx == 2'd2) begin
            state <= C_OUT;
          end else begin
            state <= C_RMW_RD;
          end
          rmw_idx <= rmw_idx + 2'd1;
        end
        C_READ_WAIT: state <= C_READ_NORM;
        C_READ_NORM: begin
          if (mmax == 64'd0) begin
            res.status <= ST_ZERO;
            state <= C_OUT;
          end else begin
            for (int i = 0; i < 3; i++) begin
              neg[i] <= sum_rd[(3-i)*ACC_WIDTH-1];
            end
            nreq.mx <= sm[0]; nreq.my <= sm[1]; nreq.mz <= sm[2];
            nreq.start <= 1'b1;
            state <= C_NORM_WAIT;
          end
        end
        C_NORM_WAIT: begin
          if (nrsp.done) begin
            res.normal_x <= neg[0] ? -nrsp.qx : nrsp.qx;
            res.normal_y <= neg[1] ? -nrsp.qy : nrsp.qy;
            res.normal_z <= neg[2] ? -nrsp.qz : nrsp.qz;
            state <= C_OUT;
          end
        end
        C_OUT: begin
          out_valid <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  assign out_item = res;

  `VNA_ASSERT_IMPL(a_one_item, clk, rst, out_valid, state == C_IDLE)
  `VNA_ASSERT_NEXT(a_hold_out, clk, rst, out_valid && out_stall, out_valid)
  `VNA_ASSERT_NEXT(a_stable_out, clk, rst, out_valid && out_stall, $stable(out_item))
  `VNA_ASSERT_IMPL(a_no_cfg_busy, clk, rst, in_valid && !in_stall, !(cfg_valid && cfg_ready))
  `VNA_ASSERT_IMPL(a_no_dual_write, clk, rst, pos_we, state == C_LOAD)

endmodule

FILE: sim/vertex_normal_accumulator_test.sv
module vertex_normal_accumulator_test;
  import vna_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxVertices = 1024;
  localparam longint AccMax = (longint'(1) <<< 47) - 1;
  localparam longint AccMin = -AccMax - 1;
  localparam int CycleLimit = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [10:0] cfg_data = '0;

  vertex_normal_accumulator DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the block's state.
  longint pos_x_mem [MaxVertices];
  longint pos_y_mem [MaxVertices];
  longint pos_z_mem [MaxVertices];
  longint acc_x_mem [MaxVertices];
  longint acc_y_mem [MaxVertices];
  longint acc_z_mem [MaxVertices];
  int unsigned vertex_limit = 0;

  in_item_t pending_items [$];
  out_item_t expected_status [$];
  int error_count = 0;
  int result_count = 0;
  int accepted_count = 0;
  int cycle_count = 0;

  // Generator bookkeeping: which vertices hold defined data.
  bit loaded [MaxVertices];
  int loaded_list [$];

  function automatic longint sat_add(longint s, longint d);
    longint r;
    r = s + d;
    if (r > AccMax) r = AccMax;
    if (r < AccMin) r = AccMin;
    return r;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Apply one item to the shadow state and return the status item it gives.
  function automatic out_item_t apply_item(in_item_t it);
    out_item_t res;
    int unsigned a, b, c, vi;
    longint e1x, e1y, e1z, e2x, e2y, e2z, cx, cy, cz;
    longint s [3];
    longint unsigned m [3];
    longint unsigned mx, len, q;
    res = '0;
    vi = it.vertex_index;
    a = it.face_a;
    b = it.face_b;
    c = it.face_c;
    case (opcode_t'(it.opcode))
      OP_LOAD: begin
        if (vi >= vertex_limit) begin
          res.status = ST_RANGE;
        end else begin
          pos_x_mem[vi] = it.pos_x;
          pos_y_mem[vi] = it.pos_y;
          pos_z_mem[vi] = it.pos_z;
          acc_x_mem[vi] = 0;
          acc_y_mem[vi] = 0;
          acc_z_mem[vi] = 0;
        end
      end
      OP_FACE: begin
        if (a >= vertex_limit || b >= vertex_limit || c >= vertex_limit) begin
          res.status = ST_RANGE;
        end else begin
          e1x = pos_x_mem[a] - pos_x_mem[b];
          e1y = pos_y_mem[a] - pos_y_mem[b];
          e1z = pos_z_mem[a] - pos_z_mem[b];
          e2x = pos_x_mem[c] - pos_x_mem[b];
          e2y = pos_y_mem[c] - pos_y_mem[b];
          e2z = pos_z_mem[c] - pos_z_mem[b];
          cx = e1y * e2z - e1z * e2y;
          cy = e1z * e2x - e1x * e2z;
          cz = e1x * e2y - e1y * e2x;
          acc_x_mem[a] = sat_add(acc_x_mem[a], cx);
          acc_y_mem[a] = sat_add(acc_y_mem[a], cy);
          acc_z_mem[a] = sat_add(acc_z_mem[a], cz);
          acc_x_mem[b] = sat_add(acc_x_mem[b], cx);
          acc_y_mem[b] = sat_add(acc_y_mem[b], cy);
          acc_z_mem[b] = sat_add(acc_z_mem[b], cz);
          acc_x_mem[c] = sat_add(acc_x_mem[c], cx);
          acc_y_mem[c] = sat_add(acc_y_mem[c], cy);
          acc_z_mem[c] = sat_add(acc_z_mem[c], cz);
        end
      end
      OP_READ: begin
        if (vi >= vertex_limit) begin
          res.status = ST_RANGE;
        end else begin
          s[0] = acc_x_mem[vi];
          s[1] = acc_y_mem[vi];
          s[2] = acc_z_mem[vi];
          for (int i = 0; i < 3; i++) m[i] = s[i] < 0 ? -s[i] : s[i];
          mx = m[0];
          if (m[1] > mx) mx = m[1];
          if (m[2] > mx) mx = m[2];
          if (mx == 0) begin
            res.status = ST_ZERO;
          end else begin
            // Bring the largest magnitude into [2^29, 2^30).
            while (mx >= (64'd1 << 30)) begin
              mx = mx >> 1;
              for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            end
            while (mx < (64'd1 << 29)) begin
              mx = mx << 1;
              for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
            end
            len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
            for (int i = 0; i < 3; i++) begin
              q = (m[i] * 16384 + len / 2) / len;
              if (s[i] < 0) q = -q;
              if (i == 0) res.normal_x = q[15:0];
              if (i == 1) res.normal_y = q[15:0];
              if (i == 2) res.normal_z = q[15:0];
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Compare results as they leave, and predict items as they enter.
  always @(posedge clk) begin
    out_item_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("vertex_normal_accumulator_test: errors");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      result_count <= result_count + 1;
      if (expected_status.size() == 0) begin
        $error("result item with no item outstanding");
        error_count = error_count + 1;
      end else begin
        want = expected_status.pop_front();
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          error_count = error_count + 1;
        end
        if (out_item.normal_x !== want.normal_x) begin
          $error("normal_x: expected %0d, got %0d", want.normal_x, out_item.normal_x);
          error_count = error_count + 1;
        end
        if (out_item.normal_y !== want.normal_y) begin
          $error("normal_y: expected %0d, got %0d", want.normal_y, out_item.normal_y);
          error_count = error_count + 1;
        end
        if (out_item.normal_z !== want.normal_z) begin
          $error("normal_z: expected %0d, got %0d", want.normal_z, out_item.normal_z);
          error_count = error_count + 1;
        end
      end
    end
    if (!rst && in_valid && !in_stall) begin
      expected_status.push_back(apply_item(in_item));
      accepted_count <= accepted_count + 1;
    end
  end

  // Sender: bursts of items separated by random gaps.
  logic in_taken = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) in_taken <= in_valid && !in_stall;

  always @(negedge clk) begin
    if (rst || (in_valid && !in_taken)) begin
      // Hold the current item until it is taken.
    end else if (gap_left > 0 || pending_items.size() == 0) begin
      in_valid <= 1'b0;
      if (gap_left > 0) gap_left <= gap_left - 1;
    end else begin
      in_valid <= 1'b1;
      in_item <= pending_items.pop_front();
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 30);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // Receiver: stall behavior switches between free, choppy and heavy modes.
  int stall_mode = 0;
  int stall_span = 0;
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_span <= $urandom_range(20, 200);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  function automatic in_item_t make_item(opcode_t op, int vi, int x, int y, int z,
                                         int a, int b, int c);
    in_item_t it;
    it.opcode = op;
    it.vertex_index = 16'(vi);
    it.pos_x = 16'(x);
    it.pos_y = 16'(y);
    it.pos_z = 16'(z);
    it.face_a = 16'(a);
    it.face_b = 16'(b);
    it.face_c = 16'(c);
    return it;
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 2047)) - 16'd1024;
      default: return 16'($urandom);
    endcase
  endfunction

  // Queue an item and note which vertex it defines.
  task automatic enqueue(in_item_t it);
    if (it.opcode == OP_LOAD && it.vertex_index < vertex_limit &&
        !loaded[it.vertex_index]) begin
      loaded[it.vertex_index] = 1'b1;
      loaded_list.push_back(it.vertex_index);
    end
    pending_items.push_back(it);
  endtask

  function automatic int pick_loaded();
    int v;
    if (loaded_list.size() == 0) return -1;
    for (int t = 0; t < 20; t++) begin
      v = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
      if (v < vertex_limit) return v;
    end
    return -1;
  endfunction

  function automatic int bad_index();
    if ($urandom_range(0, 3) == 0) return 65535;
    return $urandom_range(vertex_limit, 65535);
  endfunction

  task automatic random_item();
    in_item_t it;
    int r, a, b, c;
    it = in_item_t'($bits(in_item_t)'({$urandom, $urandom, $urandom, $urandom}));
    r = $urandom_range(0, 99);
    a = pick_loaded();
    b = pick_loaded();
    c = pick_loaded();
    if (vertex_limit == 0) begin
      it.opcode = 2'($urandom_range(0, 3));
    end else if (r < 25 || a < 0 || b < 0 || c < 0) begin
      it.opcode = OP_LOAD;
      it.vertex_index = 16'($urandom_range(0, vertex_limit - 1));
      it.pos_x = rand_coord();
      it.pos_y = rand_coord();
      it.pos_z = rand_coord();
    end else if (r < 60) begin
      it.opcode = OP_FACE;
      if ($urandom_range(0, 9) == 0) b = a;
      it.face_a = 16'(a);
      it.face_b = 16'(b);
      it.face_c = 16'(c);
    end else if (r < 80) begin
      it.opcode = OP_READ;
      it.vertex_index = 16'(a);
    end else if (r < 95) begin
      it.opcode = 2'($urandom_range(0, 2));
      it.vertex_index = 16'(bad_index());
      case ($urandom_range(0, 2))
        0: it.face_a = 16'(bad_index());
        1: it.face_b = 16'(bad_index());
        default: it.face_c = 16'(bad_index());
      endcase
    end else begin
      it.opcode = OP_NONE;
    end
    enqueue(it);
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || expected_status.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_count(int unsigned value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= 11'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    vertex_limit = value < MaxVertices ? value : MaxVertices;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned counts [6];
    counts = '{2047, 1024, 8, 1, 300, 0};
    counts[5] = $urandom_range(2, 1100);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // With no vertices in use every indexed item is rejected.
    write_count(0);
    enqueue(make_item(OP_LOAD, 0, 1, 2, 3, 0, 0, 0));
    enqueue(make_item(OP_FACE, 0, 0, 0, 0, 0, 0, 0));
    enqueue(make_item(OP_READ, 0, 0, 0, 0, 0, 0, 0));
    wait_idle();

    // Directed items: extremes, zero sum, repeated indices, range errors.
    write_count(2047);
    enqueue(make_item(OP_LOAD, 0, -32768, -32768, -32768, 0, 0, 0));
    enqueue(make_item(OP_LOAD, 1, 256, 0, 0, 0, 0, 0));
    enqueue(make_item(OP_LOAD, 2, 0, 256, 0, 0, 0, 0));
    enqueue(make_item(OP_LOAD, 1023, 32767, 32767, 32767, 0, 0, 0));
    enqueue(make_item(OP_LOAD, 1024, 5, 5, 5, 0, 0, 0));
    enqueue(make_item(OP_LOAD, 65535, -1, -1, -1, 0, 0, 0));
    enqueue(make_item(OP_READ, 0, 0, 0, 0, 0, 0, 0));
    enqueue(make_item(OP_FACE, 0, 0, 0, 0, 0, 0, 1023));
    enqueue(make_item(OP_READ, 1023, 0, 0, 0, 0, 0, 0));
    enqueue(make_item(OP_FACE, 0, 0, 0, 0, 1, 0, 2));
    enqueue(make_item(OP_FACE, 0, 0, 0, 0, 1023, 1, 2));
    enqueue(make_item(OP_FACE, 0, 0, 0, 0, 0, 1023, 1));
    enqueue(make_item(OP_READ, 0, 0, 0, 0, 0, 0, 0));
    enqueue(make_item(OP_READ, 1, 0, 0, 0, 0, 0, 0));
    enqueue(make_item(OP_READ, 2, 0, 0, 0, 0, 0, 0));
    enqueue(make_item(OP_READ, 1023, 0, 0, 0, 0, 0, 0));
    enqueue(make_item(OP_FACE, 0, 0, 0, 0, 0, 1, 1024));
    enqueue(make_item(OP_FACE, 0, 0, 0, 0, 65535, 1, 2));
    enqueue(make_item(OP_READ, 1024, 0, 0, 0, 0, 0, 0));
    enqueue(make_item(OP_READ, 65535, 0, 0, 0, 0, 0, 0));
    enqueue(make_item(OP_NONE, 65535, -1, -1, -1, 65535, 65535, 65535));

    // Random phases, each under its own vertex count.
    foreach (counts[p]) begin
      wait_idle();
      write_count(counts[p]);
      repeat (250) random_item();
    end
    wait_idle();
    repeat (100) @(posedge clk);

    $display("Ran %0d items through %0d vertex-count settings; %0d results checked.",
             accepted_count, 8, result_count);
    $display("Loads, faces, reads, range errors and zero sums were all exercised.");
    if (error_count == 0) begin
      $display("vertex_normal_accumulator_test: clean");
    end else begin
      $display("vertex_normal_accumulator_test: errors");
    end
    $finish;
  end

endmodule
